// ===== rtl/core/stlm_pkg.sv =====
// ----------------------------------------------------------------------------
// stlm_pkg
// Shared types, codes, geometry constants and the built-in font of the
// scrolling text LED matrix unit.
// ----------------------------------------------------------------------------
package stlm_pkg;

   localparam int Rows        = 6;
   localparam int Cols        = 10;
   localparam int GlyphWidth  = 4;
   localparam int BlankCols   = 10;
   localparam int FontSize    = 127;
   localparam int FullBright  = 256;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_GLYPH = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      KIND_DONE  = 2'd0,
      KIND_FULL  = 2'd1,
      KIND_PIXEL = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_FONT,
      S_ADD,
      S_TICK,
      S_DONE,
      S_RESP
   } state_type;

   function automatic logic [5:0] led_of(input logic [2:0] row, input logic [3:0] col);
      logic [2:0] band;
      logic [5:0] base;
      band = 3'(Rows - 1) - row;
      base = 6'(band) * 6'(Cols);
      if (band[0]) begin
         led_of = base + 6'(col);
      end else begin
         led_of = base + 6'(Cols - 1) - 6'(col);
      end
   endfunction

   function automatic logic [23:0] font_init(input logic [6:0] code);
      case (code)
         7'd33:  font_init = 24'd2236448;
         7'd34:  font_init = 24'd5570560;
         7'd35:  font_init = 24'd5723984;
         7'd36:  font_init = 24'd2319202;
         7'd37:  font_init = 24'd4269072;
         7'd38:  font_init = 24'd2438512;
         7'd39:  font_init = 24'd6553600;
         7'd40:  font_init = 24'd2376736;
         7'd41:  font_init = 24'd4334144;
         7'd42:  font_init = 24'd5403216;
         7'd43:  font_init = 24'd160256;
         7'd44:  font_init = 24'd50;
         7'd45:  font_init = 24'd28672;
         7'd46:  font_init = 24'd32;
         7'd47:  font_init = 24'd1123392;
         7'd48:  font_init = 24'd3495264;
         7'd49:  font_init = 24'd2499184;
         7'd50:  font_init = 24'd6366320;
         7'd51:  font_init = 24'd6365536;
         7'd52:  font_init = 24'd1405200;
         7'd53:  font_init = 24'd7627104;
         7'd54:  font_init = 24'd2385184;
         7'd55:  font_init = 24'd7414304;
         7'd56:  font_init = 24'd2434336;
         7'd57:  font_init = 24'd2437408;
         7'd58:  font_init = 24'd8224;
         7'd59:  font_init = 24'd8292;
         7'd60:  font_init = 24'd1196560;
         7'd61:  font_init = 24'd28784;
         7'd62:  font_init = 24'd4330048;
         7'd63:  font_init = 24'd6365216;
         7'd64:  font_init = 24'd7689328;
         7'd65:  font_init = 24'd2454864;
         7'd66:  font_init = 24'd6645088;
         7'd67:  font_init = 24'd3425328;
         7'd68:  font_init = 24'd6640992;
         7'd69:  font_init = 24'd7627888;
         7'd70:  font_init = 24'd7627840;
         7'd71:  font_init = 24'd3429680;
         7'd72:  font_init = 24'd5600592;
         7'd73:  font_init = 24'd7479920;
         7'd74:  font_init = 24'd1119520;
         7'd75:  font_init = 24'd5596496;
         7'd76:  font_init = 24'd4473968;
         7'd77:  font_init = 24'd5731664;
         7'd78:  font_init = 24'd5723472;
         7'd79:  font_init = 24'd2446624;
         7'd80:  font_init = 24'd6644800;
         7'd81:  font_init = 24'd2446640;
         7'd82:  font_init = 24'd6645072;
         7'd83:  font_init = 24'd3436896;
         7'd84:  font_init = 24'd7479840;
         7'd85:  font_init = 24'd5592432;
         7'd86:  font_init = 24'd5592352;
         7'd87:  font_init = 24'd5601104;
         7'd88:  font_init = 24'd5580112;
         7'd89:  font_init = 24'd5579296;
         7'd90:  font_init = 24'd7414896;
         7'd91:  font_init = 24'd6571104;
         7'd92:  font_init = 24'd4464912;
         7'd93:  font_init = 24'd6431328;
         7'd94:  font_init = 24'd2424832;
         7'd95:  font_init = 24'd15;
         7'd96:  font_init = 24'd6422528;
         7'd97:  font_init = 24'd13680;
         7'd98:  font_init = 24'd4482400;
         7'd99:  font_init = 24'd13360;
         7'd100: font_init = 24'd1127728;
         7'd101: font_init = 24'd30256;
         7'd102: font_init = 24'd1208864;
         7'd103: font_init = 24'd29975;
         7'd104: font_init = 24'd4482384;
         7'd105: font_init = 24'd2105888;
         7'd106: font_init = 24'd2105894;
         7'd107: font_init = 24'd4478544;
         7'd108: font_init = 24'd2236960;
         7'd109: font_init = 24'd30544;
         7'd110: font_init = 24'd25936;
         7'd111: font_init = 24'd9504;
         7'd112: font_init = 24'd25956;
         7'd113: font_init = 24'd13617;
         7'd114: font_init = 24'd25664;
         7'd115: font_init = 24'd12896;
         7'd116: font_init = 24'd160304;
         7'd117: font_init = 24'd21872;
         7'd118: font_init = 24'd21792;
         7'd119: font_init = 24'd22384;
         7'd120: font_init = 24'd21072;
         7'd121: font_init = 24'd21796;
         7'd122: font_init = 24'd25136;
         7'd123: font_init = 24'd3301936;
         7'd124: font_init = 24'd2236960;
         7'd125: font_init = 24'd6435424;
         7'd126: font_init = 24'd5898240;
         default: font_init = 24'd0;
      endcase
   endfunction

endpackage

// ===== rtl/core/stlm_ram.sv =====
// ----------------------------------------------------------------------------
// stlm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module stlm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/scrolling_text_led_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// scrolling_text_led_matrix_unit
// Scrolling marquee engine for a 10x6 serpentine RGB LED matrix.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: clear, add letter, scroll tick or font glyph
//   write. req_stall is high while a request is in progress; the block works
//   on one request at a time. rsp_* returns results under rsp_stall.
//   csr_wr_en / csr_wr_data write the brightness scale (256 = full scale).
// Request sequences:
//   Glyph write: 1 status result. Refused add: 1 full status result.
//   Add letter: a font read, then 24 buffer writes and a status result.
//   Clear: 60 buffer writes, then a status result.
//   Scroll tick: 60 pixel results, one per cycle from the column buffer
//   read port while the output is not stalled; an empty buffer gives one status.
// Reset:
//   Restores the built-in font through per-glyph valid bits, empties the
//   buffer and sets brightness to full. No clearing pass is needed.
// Stalls:
//   A stalled result holds in the output register; the sequencer holds
//   its buffer reads until the pending pixel has moved out.
// ----------------------------------------------------------------------------
module scrolling_text_led_matrix_unit #(
   parameter int BUFFER_COLUMNS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [23:0] req_glyph_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_led_index,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_scroll_done,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   localparam int UW = $clog2(BUFFER_COLUMNS + 1);
   localparam int AW = $clog2(BUFFER_COLUMNS * stlm_pkg::Rows);

   stlm_pkg::state_type state_ff, state_in;

   logic [8:0]      bri_ff, bri_in;
   logic [UW-1:0]   used_ff, used_in;
   logic [UW-1:0]   pos_ff, pos_in;
   logic [UW-1:0]   src_ff, src_in;
   logic [UW-1:0]   src0_ff, src0_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [2:0]      row_ff, row_in;
   logic [3:0]      col_ff, col_in;
   logic            done_ff, done_in;
   logic [6:0]      code_ff, code_in;
   logic [23:0]     color_ff, color_in;
   logic [23:0]     mask_ff, mask_in;
   logic [stlm_pkg::FontSize-1:0] fvalid_ff, fvalid_in;
   stlm_pkg::kind_type stat_ff, stat_in;
   logic            pend_ff, pend_in;
   logic [5:0]      pend_led_ff, pend_led_in;
   logic            pend_last_ff, pend_last_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_kind_ff, rsp_kind_in;
   logic [5:0]      rsp_led_ff, rsp_led_in;
   logic [7:0]      rsp_r_ff, rsp_r_in;
   logic [7:0]      rsp_g_ff, rsp_g_in;
   logic [7:0]      rsp_b_ff, rsp_b_in;
   logic            rsp_done_ff, rsp_done_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            buf_we, buf_re, font_we, font_re;
   logic [AW-1:0]   buf_waddr, buf_raddr;
   logic [23:0]     buf_wdata, buf_rdata, font_rdata;

   logic            req_acc, out_free, load_pix, issue;
   logic            row_end, pass_end, add_end;
   logic            full;
   logic [6:0]      code_mod;
   logic [UW-1:0]   src_next;
   logic [8:0]      bri_eff;
   logic [16:0]     prod_r, prod_g, prod_b;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_pix = pend_ff && out_free;
   assign issue    = (state_ff == stlm_pkg::S_TICK) && (!pend_ff || load_pix);
   assign row_end  = col_ff == 4'(stlm_pkg::Cols - 1);
   assign pass_end = row_end && (row_ff == 3'(stlm_pkg::Rows - 1));
   assign add_end  = (col_ff == 4'(stlm_pkg::GlyphWidth - 1))
                     && (row_ff == 3'(stlm_pkg::Rows - 1));
   assign full     = ({1'b0, used_ff} + (UW+1)'(stlm_pkg::GlyphWidth))
                     > (UW+1)'(BUFFER_COLUMNS);
   assign code_mod = (req_char_code >= 8'(2 * stlm_pkg::FontSize))
                     ? 7'(req_char_code - 8'(2 * stlm_pkg::FontSize))
                     : (req_char_code >= 8'(stlm_pkg::FontSize))
                     ? 7'(req_char_code - 8'(stlm_pkg::FontSize)) : req_char_code[6:0];
   assign src_next = (src_ff + 1'b1 == used_ff) ? '0 : src_ff + 1'b1;
   assign bri_eff  = (bri_ff > 9'(stlm_pkg::FullBright)) ? 9'(stlm_pkg::FullBright) : bri_ff;
   assign prod_r   = 17'(buf_rdata[23:16]) * 17'(bri_eff);
   assign prod_g   = 17'(buf_rdata[15:8]) * 17'(bri_eff);
   assign prod_b   = 17'(buf_rdata[7:0]) * 17'(bri_eff);
   assign req_stall = state_ff != stlm_pkg::S_IDLE;

   stlm_ram #(.WIDTH(24), .DEPTH(BUFFER_COLUMNS * stlm_pkg::Rows)) u_column_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_en   (buf_re),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   stlm_ram #(.WIDTH(24), .DEPTH(stlm_pkg::FontSize)) u_font_ram (
      .clock   (clock),
      .wr_en   (font_we),
      .wr_addr (code_mod),
      .wr_data (req_glyph_bits),
      .rd_en   (font_re),
      .rd_addr (code_mod),
      .rd_data (font_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stlm_pkg::S_IDLE: begin
            if (req_acc) begin
               case (req_type)
                  stlm_pkg::REQ_CLEAR: state_in = stlm_pkg::S_CLEAR;
                  stlm_pkg::REQ_ADD:   state_in = full ? stlm_pkg::S_RESP : stlm_pkg::S_FONT;
                  stlm_pkg::REQ_TICK:  state_in = (used_ff == '0) ? stlm_pkg::S_RESP
                                                                   : stlm_pkg::S_TICK;
                  default:             state_in = stlm_pkg::S_RESP;
               endcase
            end
         end
         stlm_pkg::S_CLEAR: if (pass_end) state_in = stlm_pkg::S_RESP;
         stlm_pkg::S_FONT:  state_in = stlm_pkg::S_ADD;
         stlm_pkg::S_ADD:   if (add_end) state_in = stlm_pkg::S_RESP;
         stlm_pkg::S_TICK:  if (issue && pass_end) state_in = stlm_pkg::S_DONE;
         stlm_pkg::S_DONE:  if (!pend_ff) state_in = stlm_pkg::S_IDLE;
         stlm_pkg::S_RESP:  if (out_free) state_in = stlm_pkg::S_IDLE;
         default:           state_in = stlm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      bri_in       = csr_wr_en ? csr_wr_data : bri_ff;
      used_in      = used_ff;
      pos_in       = pos_ff;
      src_in       = src_ff;
      src0_in      = src0_ff;
      base_in      = base_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      done_in      = done_ff;
      code_in      = code_ff;
      color_in     = color_ff;
      mask_in      = mask_ff;
      fvalid_in    = fvalid_ff;
      stat_in      = stat_ff;
      pend_in      = pend_ff;
      pend_led_in  = pend_led_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_led_in   = rsp_led_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;
      buf_we       = 1'b0;
      buf_waddr    = '0;
      buf_wdata    = '0;
      buf_re       = 1'b0;
      buf_raddr    = '0;
      font_we      = 1'b0;
      font_re      = 1'b0;

      case (state_ff)
         stlm_pkg::S_IDLE: begin
            if (req_acc) begin
               code_in  = code_mod;
               color_in = {req_red_in, req_green_in, req_blue_in};
               stat_in  = stlm_pkg::KIND_DONE;
               row_in   = '0;
               col_in   = '0;
               base_in  = '0;
               case (req_type)
                  stlm_pkg::REQ_ADD: begin
                     if (full) begin
                        stat_in = stlm_pkg::KIND_FULL;
                     end else begin
                        font_re = 1'b1;
                     end
                  end
                  stlm_pkg::REQ_GLYPH: begin
                     font_we = 1'b1;
                     fvalid_in[code_mod] = 1'b1;
                  end
                  stlm_pkg::REQ_TICK: begin
                     if (used_ff != '0) begin
                        done_in = pos_ff == used_ff;
                        src0_in = (pos_ff == used_ff) ? '0 : pos_ff;
                        src_in  = (pos_ff == used_ff) ? '0 : pos_ff;
                        pos_in  = ((pos_ff == used_ff) ? '0 : pos_ff) + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         stlm_pkg::S_CLEAR: begin
            buf_we    = 1'b1;
            buf_waddr = base_ff + AW'(col_ff);
            col_in    = col_ff + 1'b1;
            if (row_end) begin
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               base_in = base_ff + AW'(BUFFER_COLUMNS);
            end
            if (pass_end) begin
               used_in = UW'(stlm_pkg::BlankCols);
               pos_in  = '0;
            end
         end
         stlm_pkg::S_FONT: begin
            mask_in = fvalid_ff[code_ff] ? font_rdata : stlm_pkg::font_init(code_ff);
         end
         stlm_pkg::S_ADD: begin
            buf_we    = 1'b1;
            buf_waddr = base_ff + AW'(used_ff) + AW'(col_ff);
            buf_wdata = mask_ff[23] ? color_ff : '0;
            mask_in   = {mask_ff[22:0], 1'b0};
            col_in    = col_ff + 1'b1;
            if (col_ff == 4'(stlm_pkg::GlyphWidth - 1)) begin
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               base_in = base_ff + AW'(BUFFER_COLUMNS);
            end
            if (add_end) begin
               used_in = used_ff + UW'(stlm_pkg::GlyphWidth);
            end
         end
         stlm_pkg::S_TICK: begin
            if (issue) begin
               buf_re       = 1'b1;
               buf_raddr    = base_ff + AW'(src_ff);
               pend_led_in  = stlm_pkg::led_of(row_ff, col_ff);
               pend_last_in = pass_end;
               col_in       = col_ff + 1'b1;
               src_in       = src_next;
               if (row_end) begin
                  col_in  = '0;
                  row_in  = row_ff + 1'b1;
                  base_in = base_ff + AW'(BUFFER_COLUMNS);
                  src_in  = src0_ff;
               end
            end
         end
         stlm_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = stat_ff;
               rsp_led_in   = '0;
               rsp_r_in     = '0;
               rsp_g_in     = '0;
               rsp_b_in     = '0;
               rsp_done_in  = 1'b0;
               rsp_last_in  = 1'b1;
            end
         end
         default: ;
      endcase

      if (load_pix) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = stlm_pkg::KIND_PIXEL;
         rsp_led_in   = pend_led_ff;
         rsp_r_in     = prod_r[15:8];
         rsp_g_in     = prod_g[15:8];
         rsp_b_in     = prod_b[15:8];
         rsp_done_in  = done_ff;
         rsp_last_in  = pend_last_ff;
      end
      if (issue) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stlm_pkg::S_IDLE;
         bri_ff       <= 9'(stlm_pkg::FullBright);
         used_ff      <= '0;
         pos_ff       <= '0;
         fvalid_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bri_ff       <= bri_in;
         used_ff      <= used_in;
         pos_ff       <= pos_in;
         fvalid_ff    <= fvalid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      src0_ff      <= src0_in;
      base_ff      <= base_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      done_ff      <= done_in;
      code_ff      <= code_in;
      color_ff     <= color_in;
      mask_ff      <= mask_in;
      stat_ff      <= stat_in;
      pend_led_ff  <= pend_led_in;
      pend_last_ff <= pend_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_led_ff   <= rsp_led_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_g_ff     <= rsp_g_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_led_index   = rsp_led_ff;
   assign rsp_red_out     = rsp_r_ff;
   assign rsp_green_out   = rsp_g_ff;
   assign rsp_blue_out    = rsp_b_ff;
   assign rsp_scroll_done = rsp_done_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(BUFFER_COLUMNS))
      else $error("used column count beyond buffer");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= used_ff)
      else $error("scroll position past used columns");
   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == stlm_pkg::S_TICK || state_ff == stlm_pkg::S_DONE))
      else $error("pixel pending outside a tick");
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_type == stlm_pkg::REQ_TICK && used_ff != '0)
      |=> state_ff == stlm_pkg::S_TICK)
      else $error("tick did not start pixel sweep");
`endif

endmodule

// ===== tb/scrolling_text_led_matrix_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrolling_text_led_matrix_unit_tb
// Self-checking bench for the scrolling marquee engine. Clears, letter adds,
// glyph writes and scroll ticks are sent under random idling and stalling;
// a local marquee predictor tracks font, column buffer, scroll position and
// brightness, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module scrolling_text_led_matrix_unit_tb;

   localparam int BufCols  = 256;
   localparam int Drain    = 80;

   localparam logic [23:0] FONT_ROM [0:126] = '{
      24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
      24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
      24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
      24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
      24'd0, 24'd2236448, 24'd5570560, 24'd5723984, 24'd2319202, 24'd4269072,
      24'd2438512, 24'd6553600, 24'd2376736, 24'd4334144, 24'd5403216,
      24'd160256, 24'd50, 24'd28672, 24'd32, 24'd1123392, 24'd3495264,
      24'd2499184, 24'd6366320, 24'd6365536, 24'd1405200, 24'd7627104,
      24'd2385184, 24'd7414304, 24'd2434336, 24'd2437408, 24'd8224, 24'd8292,
      24'd1196560, 24'd28784, 24'd4330048, 24'd6365216, 24'd7689328,
      24'd2454864, 24'd6645088, 24'd3425328, 24'd6640992, 24'd7627888,
      24'd7627840, 24'd3429680, 24'd5600592, 24'd7479920, 24'd1119520,
      24'd5596496, 24'd4473968, 24'd5731664, 24'd5723472, 24'd2446624,
      24'd6644800, 24'd2446640, 24'd6645072, 24'd3436896, 24'd7479840,
      24'd5592432, 24'd5592352, 24'd5601104, 24'd5580112, 24'd5579296,
      24'd7414896, 24'd6571104, 24'd4464912, 24'd6431328, 24'd2424832, 24'd15,
      24'd6422528, 24'd13680, 24'd4482400, 24'd13360, 24'd1127728, 24'd30256,
      24'd1208864, 24'd29975, 24'd4482384, 24'd2105888, 24'd2105894,
      24'd4478544, 24'd2236960, 24'd30544, 24'd25936, 24'd9504, 24'd25956,
      24'd13617, 24'd25664, 24'd12896, 24'd160304, 24'd21872, 24'd21792,
      24'd22384, 24'd21072, 24'd21796, 24'd25136, 24'd3301936, 24'd2236960,
      24'd6435424, 24'd5898240
   };

   typedef struct packed {
      stlm_pkg::kind_type kind;
      logic [5:0] led;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       done;
      logic       last;
   } marquee_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = stlm_pkg::REQ_CLEAR;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic [23:0] req_glyph_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [5:0]  rsp_led_index;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_scroll_done;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;

   logic [23:0] font_mem [0:126];
   logic [23:0] column_mem [0:BufCols*stlm_pkg::Rows-1];
   int unsigned used_cols;
   int unsigned scroll_pos;
   int unsigned bright_reg;
   marquee_result_type pending_results [$];
   int error_count = 0;
   int sender_idle_pct = 0;
   int stall_pct = 0;

   scrolling_text_led_matrix_unit #(.BUFFER_COLUMNS(BufCols)) dut (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("scrolling_text_led_matrix_unit verification failed");
      $finish;
   end

   function automatic logic [5:0] physical_led(int unsigned row, int unsigned col);
      int unsigned band;
      band = stlm_pkg::Rows - 1 - row;
      return 6'((band % 2) ? band * stlm_pkg::Cols + col
                           : band * stlm_pkg::Cols + stlm_pkg::Cols - 1 - col);
   endfunction

   function automatic logic [7:0] dim(logic [7:0] c, int unsigned b);
      return 8'((c * b) >> 8);
   endfunction

   function automatic void push_status(stlm_pkg::kind_type k);
      marquee_result_type r;
      r = '0;
      r.kind = k;
      r.last = 1'b1;
      pending_results.push_back(r);
   endfunction

   function automatic void render_request(stlm_pkg::req_type_type op, logic [7:0] code,
         logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [23:0] glyph);
      int unsigned idx, nib, bri, src;
      logic done;
      logic [23:0] px;
      marquee_result_type res;
      idx = code % stlm_pkg::FontSize;
      case (op)
         stlm_pkg::REQ_CLEAR: begin
            for (int row = 0; row < stlm_pkg::Rows; row++)
               for (int col = 0; col < stlm_pkg::BlankCols; col++)
                  column_mem[row*BufCols + col] = '0;
            used_cols = stlm_pkg::BlankCols;
            scroll_pos = 0;
            push_status(stlm_pkg::KIND_DONE);
         end
         stlm_pkg::REQ_ADD: begin
            if (used_cols + stlm_pkg::GlyphWidth > BufCols) begin
               push_status(stlm_pkg::KIND_FULL);
            end else begin
               for (int row = 0; row < stlm_pkg::Rows; row++) begin
                  nib = (font_mem[idx] >> (20 - 4*row)) & 4'hF;
                  for (int col = 0; col < stlm_pkg::GlyphWidth; col++)
                     column_mem[row*BufCols + used_cols + col] =
                        ((nib >> (3 - col)) & 1) ? {r, g, b} : 24'd0;
               end
               used_cols += stlm_pkg::GlyphWidth;
               push_status(stlm_pkg::KIND_DONE);
            end
         end
         stlm_pkg::REQ_GLYPH: begin
            font_mem[idx] = glyph;
            push_status(stlm_pkg::KIND_DONE);
         end
         default: begin
            if (used_cols == 0) begin
               push_status(stlm_pkg::KIND_DONE);
            end else begin
               bri = (bright_reg > stlm_pkg::FullBright) ? stlm_pkg::FullBright : bright_reg;
               done = (scroll_pos == used_cols);
               for (int row = 0; row < stlm_pkg::Rows; row++)
                  for (int col = 0; col < stlm_pkg::Cols; col++) begin
                     src = (scroll_pos + col) % used_cols;
                     px = column_mem[row*BufCols + src];
                     res.kind  = stlm_pkg::KIND_PIXEL;
                     res.led   = physical_led(row, col);
                     res.red   = dim(px[23:16], bri);
                     res.green = dim(px[15:8], bri);
                     res.blue  = dim(px[7:0], bri);
                     res.done  = done;
                     res.last  = (row == stlm_pkg::Rows - 1) && (col == stlm_pkg::Cols - 1);
                     pending_results.push_back(res);
                  end
               if (done) scroll_pos = 0;
               scroll_pos = (scroll_pos + 1) & 16'hFFFF;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      marquee_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%t unexpected result: expected none, actual kind %0d",
                     $realtime, rsp_kind);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if ({rsp_kind, rsp_led_index, rsp_red_out, rsp_green_out, rsp_blue_out,
                 rsp_scroll_done, rsp_last} !== want) begin
               $display("%t mismatch: expected kind %0d led %0d rgb %h/%h/%h done %b last %b",
                        $realtime, want.kind, want.led, want.red, want.green, want.blue,
                        want.done, want.last);
               $display("%t          actual kind %0d led %0d rgb %h/%h/%h done %b last %b",
                        $realtime, rsp_kind, rsp_led_index, rsp_red_out, rsp_green_out,
                        rsp_blue_out, rsp_scroll_done, rsp_last);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_request(stlm_pkg::req_type_type op, logic [7:0] code = 8'd0,
         logic [7:0] r = 8'd0, logic [7:0] g = 8'd0, logic [7:0] b = 8'd0,
         logic [23:0] glyph = 24'd0);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_char_code  <= code;
      req_red_in     <= r;
      req_green_in   <= g;
      req_blue_in    <= b;
      req_glyph_bits <= glyph;
      do @(posedge clock); while (req_stall);
      render_request(op, code, r, g, b, glyph);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   task automatic write_brightness(logic [8:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bright_reg = value;
   endtask

   task automatic send_random_request();
      int unsigned pick;
      stlm_pkg::req_type_type op;
      pick = $urandom_range(99);
      op = (pick < 3) ? stlm_pkg::REQ_CLEAR : (pick < 40) ? stlm_pkg::REQ_ADD :
           (pick < 88) ? stlm_pkg::REQ_TICK : stlm_pkg::REQ_GLYPH;
      send_request(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   24'($urandom));
   endtask

   task automatic test_empty_buffer();
      send_request(stlm_pkg::REQ_TICK);
      send_request(stlm_pkg::REQ_TICK);
   endtask

   task automatic test_directed();
      send_request(stlm_pkg::REQ_GLYPH, 8'd254, 8'd0, 8'd0, 8'd0, 24'hFFFFFF);
      send_request(stlm_pkg::REQ_ADD, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_request(stlm_pkg::REQ_CLEAR);
      send_request(stlm_pkg::REQ_ADD, 8'd127, 8'hFF, 8'h00, 8'hA5);
      send_request(stlm_pkg::REQ_ADD, 8'd255, 8'h01, 8'h80, 8'hFF);
      send_request(stlm_pkg::REQ_ADD, 8'd65, 8'hFF, 8'hFF, 8'hFF);
      send_request(stlm_pkg::REQ_GLYPH, 8'd0, 8'd0, 8'd0, 8'd0, 24'd0);
      send_request(stlm_pkg::REQ_ADD, 8'd127, 8'h55, 8'hAA, 8'h33);
      repeat (15) send_request(stlm_pkg::REQ_TICK);
      write_brightness(9'd0);
      send_request(stlm_pkg::REQ_TICK);
      write_brightness(9'd511);
      send_request(stlm_pkg::REQ_TICK);
      write_brightness(9'd128);
      send_request(stlm_pkg::REQ_TICK);
      write_brightness(9'd256);
   endtask

   task automatic test_buffer_full();
      send_request(stlm_pkg::REQ_CLEAR);
      repeat (63) send_request(stlm_pkg::REQ_ADD, 8'($urandom_range(33, 126)), 8'($urandom),
                               8'($urandom), 8'($urandom));
      send_request(stlm_pkg::REQ_TICK);
      send_request(stlm_pkg::REQ_CLEAR);
   endtask

   task automatic test_random_phase(int idle, int stall, logic [8:0] bri, int count);
      write_brightness(bri);
      sender_idle_pct = idle;
      stall_pct = stall;
      send_request(stlm_pkg::REQ_CLEAR);
      repeat (count) send_random_request();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (font_mem[i]) font_mem[i] = FONT_ROM[i];
      used_cols = 0;
      scroll_pos = 0;
      bright_reg = stlm_pkg::FullBright;
      test_empty_buffer();
      test_directed();
      test_buffer_full();
      test_random_phase(0, 0, 9'd256, 58);
      test_random_phase(77, 0, 9'd0, 58);
      wait_drained();
      test_random_phase(0, 77, 9'd511, 58);
      test_random_phase(27, 27, 9'($urandom), 58);
      wait_drained();
      if (error_count == 0) begin
         $display("scrolling_text_led_matrix_unit verification clean");
      end else begin
         $display("scrolling_text_led_matrix_unit verification failed");
      end
      $finish;
   end

endmodule
